/* design/mtkd_pkg.sv */
// Package for the multi-tap key detector: field widths, reset values,
// register indexes, the configuration struct and the key scan function.
// No dependencies.
package mtkd_pkg;

  localparam int KEY_LINES = 8;   // key lines carried by the scan field
  localparam int KEY_W     = 8;   // key_levels field width
  localparam int KEYNUM_W  = 4;   // key number 0..KEY_LINES
  localparam int TICK_W    = 32;  // tick_now field width
  localparam int CFG_W     = 16;  // register width
  localparam int TAPCNT_W  = 2;   // tap_count field width

  localparam int DEF_MAX_TAPS = 3;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd150;
  localparam logic [CFG_W-1:0] MIN_GAP_RST = 16'd10;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_GAP = 2'd1;

  typedef struct packed {
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] min_gap;
  } cfg_t;

  // Lowest low line, numbered from 1; 0 when no line is low.
  function automatic logic [KEYNUM_W-1:0] scan_key(input logic [KEY_W-1:0] levels);
    logic [KEYNUM_W-1:0] k;
    k = '0;
    for (int i = KEY_LINES - 1; i >= 0; i--) begin
      if (!levels[i]) k = KEYNUM_W'(i + 1);
    end
    return k;
  endfunction

endpackage

/* design/multi_tap_key_detector.sv */
// Top level of the multi-tap key detector: stream ports, configuration
// registers, input and result registers. Depends on mtkd_pkg and mtkd_core.
//
// Usage:
//  - Slave stream: one transaction per poll tick, tdata carrying the scan
//    of the active-low key lines and the tick time of the poll.
//  - Master stream: exactly one transaction per scan, tdata carrying the
//    finished tap count (1..3), or 0 when nothing is reported on that scan.
//  - Config channel: cfg_addr_i selects the register (0 = tap timeout,
//    1 = minimum tap gap), cfg_wdata_i is the value. Always ready; writes
//    to other indexes are dropped. Write only while the block is idle.
//  - Path: an accepted scan passes the input register, then the tap update
//    into the result register.
//  - Throughput: one scan per cycle while results are taken, set by the
//    update of the tap state (one 32-bit subtract-and-compare per time check).
//  - Stall: while the result register is held by a low m_axis_tready_i,
//    the input register still takes one more scan, then s_axis_tready_o
//    drops until the result moves on. Nothing is lost or repeated.
//  - Reset: both registers empty, no key held, no open sequence, tap
//    timeout 150 ticks, minimum gap 10 ticks.
module multi_tap_key_detector import mtkd_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave stream; tdata: [7:0] key_levels, [39:8] tick_now
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [39:0]          s_axis_tdata_i,
  // master stream; tdata: [1:0] tap_count, [7:2] zero
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t cfg_q;

  logic                in_vld_q;
  logic [KEY_W-1:0]    in_key_q;
  logic [TICK_W-1:0]   in_tick_q;

  logic                out_vld_q;
  logic [TAPCNT_W-1:0] out_cnt_q;
  logic [TAPCNT_W-1:0] core_cnt;

  logic out_free;   // result register can take a new value
  logic s_hs;       // input transaction this cycle
  logic adv;        // input register moves into the result register

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign adv             = in_vld_q && out_free;
  assign cfg_ready_o     = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= TIMEOUT_RST;
      cfg_q.min_gap <= MIN_GAP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_IDX_TIMEOUT: cfg_q.timeout <= cfg_wdata_i;
        CFG_IDX_MIN_GAP: cfg_q.min_gap <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register: control reset, payload loaded on transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_key_q  <= s_axis_tdata_i[7:0];
      in_tick_q <= s_axis_tdata_i[39:8];
    end
  end

  mtkd_core #(
    .MAX_TAPS(MAX_TAPS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .key_levels_i(in_key_q),
    .tick_now_i  (in_tick_q),
    .cfg_i       (cfg_q),
    .tap_count_o (core_cnt)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cnt_q <= core_cnt;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(8 - TAPCNT_W){1'b0}}, out_cnt_q};

  // The core only steps on a scan that really moves to the result register.
  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("processed scan did not reach result register");

  // Input is blocked only when both registers are occupied.
  a_block_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with room in the pipeline");

  // A result held by the receiver is not overwritten.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=> $stable(out_cnt_q))
    else $error("stalled result changed");

endmodule

/* design/mtkd_core.sv */
// Tap tracking state and per-scan update logic of the multi-tap key detector.
// Depends on mtkd_pkg.
module mtkd_core import mtkd_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,          // one scan processed this cycle
  input  logic [KEY_W-1:0]    key_levels_i,
  input  logic [TICK_W-1:0]   tick_now_i,
  input  cfg_t                cfg_i,
  output logic [TAPCNT_W-1:0] tap_count_o    // valid while en_i
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  logic                key_held_q, key_held_d;
  logic [KEYNUM_W-1:0] held_key_q, held_key_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TICK_W-1:0]   last_q, last_d;
  logic [TICK_W-1:0]   first_q, first_d;

  logic [KEYNUM_W-1:0] key;
  logic                tap;
  logic [TICK_W-1:0]   gap_last, gap_first;
  logic                gap_ok, timed_out, seq_over;
  logic [CNT_W-1:0]    report;

  assign key       = scan_key(key_levels_i);
  assign tap       = (key == '0) && key_held_q;
  assign gap_last  = tick_now_i - last_q;
  assign gap_first = tick_now_i - first_q;
  assign gap_ok    = gap_last >= TICK_W'(cfg_i.min_gap);
  assign timed_out = gap_last > TICK_W'(cfg_i.timeout);
  assign seq_over  = gap_first > TICK_W'(cfg_i.timeout);

  always_comb begin
    key_held_d = key_held_q;
    held_key_d = held_key_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    first_d    = first_q;
    report     = '0;

    if (key != '0) begin
      key_held_d = 1'b1;
      held_key_d = key;
    end else if (key_held_q) begin
      key_held_d = 1'b0;
      held_key_d = '0;
    end

    if (tap) begin
      if (cnt_q == '0) begin
        cnt_d   = CNT_W'(1);
        first_d = tick_now_i;
        last_d  = tick_now_i;
      end else if (gap_ok) begin
        // late tap restarts; otherwise count up, saturating
        if (timed_out) begin
          cnt_d   = CNT_W'(1);
          first_d = tick_now_i;
        end else if (cnt_q < CNT_W'(MAX_TAPS)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        last_d = tick_now_i;
      end
    end else if (cnt_q != '0 && seq_over && gap_ok) begin
      report = cnt_q;
      cnt_d  = '0;
    end
  end

  assign tap_count_o = report[TAPCNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_held_q <= 1'b0;
      held_key_q <= '0;
      cnt_q      <= '0;
      last_q     <= '0;
      first_q    <= '0;
    end else if (en_i) begin
      key_held_q <= key_held_d;
      held_key_q <= held_key_d;
      cnt_q      <= cnt_d;
      last_q     <= last_d;
      first_q    <= first_d;
    end
  end

  // Count never passes its ceiling.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TAPS))
    else $error("tap counter above MAX_TAPS");

  // A held key always has a number, and a released one has none.
  a_held_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_held_q == (held_key_q != '0))
    else $error("held key flag and number disagree");

  // Reporting a count closes the sequence.
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && report != '0) |=> cnt_q == '0)
    else $error("count not cleared after report");

endmodule
